// File: design/hwi_pkg.sv
// Shared types and constants for the homography warp index block.
package hwi_pkg;

  // Coefficient format: signed Q16.32 in 48 bits
  localparam int COEF_W   = 48;
  localparam int NUM_COEF = 8;
  localparam int FRAC_W   = 32;

  // Field widths of the stream payloads
  localparam int FIELD_W  = 12;
  localparam int IN_W     = 24;
  localparam int OUT_W    = 32;

  // Quotient bits kept by the divider; one more step flags overflow
  localparam int QB       = 13;

  typedef logic signed [COEF_W-1:0] coef_t;

  // Register indexes of the configuration port
  typedef enum logic [2:0] {
    IDX_A = 3'd0,
    IDX_B = 3'd1,
    IDX_C = 3'd2,
    IDX_D = 3'd3,
    IDX_E = 3'd4,
    IDX_F = 3'd5,
    IDX_G = 3'd6,
    IDX_H = 3'd7
  } cfg_idx_t;

  // Flags that ride alongside the divider chain
  typedef struct packed {
    logic wz;    // denominator was zero
    logic negc;  // column quotient negative
    logic negr;  // row quotient negative
  } hwi_side_t;

endpackage

// File: design/homography_warp_index_top.sv
// Top level of the homography warp index block.
//
//   channel | dir | handshake           | payload
//   in_     | in  | tvalid/tready       | tdata: dest_col, dest_row
//   out_    | out | tvalid/tready       | tdata: inside_res, src_row, src_col
//   cfg_    | in  | we (no wait)        | idx, wdata: coef_a .. coef_h
//
// One item per clock while out_tready holds; 3 front-end stages,
// 14 division steps, 1 output register. Each division step is one stage
// with one wide compare per coordinate; the top step does not subtract.
// Reset clears valid bits and loads the identity homography.
// A stall on out_tready freezes the whole pipeline; in_tready drops with it.
module homography_warp_index_top #(
  parameter int SRC_WIDTH  = 640,
  parameter int SRC_HEIGHT = 480,
  parameter int COORD_BITS = 12
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [hwi_pkg::IN_W-1:0]      in_tdata,   // dest_col, dest_row
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [hwi_pkg::OUT_W-1:0]     out_tdata,  // inside_res, src_row, src_col
  input  logic                          cfg_we,
  input  logic [2:0]                    cfg_idx,
  input  logic [hwi_pkg::COEF_W-1:0]    cfg_wdata
);

  localparam int CB = (COORD_BITS < hwi_pkg::FIELD_W) ? COORD_BITS : hwi_pkg::FIELD_W;
  localparam int SW = hwi_pkg::COEF_W + CB + 3;
  localparam int NW = SW + 1;
  localparam int QB = hwi_pkg::QB;
  localparam int NS = QB + 1;
  localparam logic [QB-1:0] LIM_C = QB'(SRC_WIDTH);
  localparam logic [QB-1:0] LIM_R = QB'(SRC_HEIGHT);
  localparam logic signed [hwi_pkg::COEF_W-1:0] ONE_C =
    hwi_pkg::COEF_W'(64'sh1_0000_0000);

  hwi_pkg::coef_t     coef_r [hwi_pkg::NUM_COEF];
  logic               en;
  logic               fe_vld;
  logic [NW-1:0]      fe_nc, fe_nr, fe_d;
  hwi_pkg::hwi_side_t fe_side;

  logic               vld_r  [NS];
  hwi_pkg::hwi_side_t side_r [NS];

  logic [NW-1:0] dc [NS+1];
  logic [NW-1:0] dr [NS+1];
  logic [NW-1:0] rc [NS+1];
  logic [NW-1:0] rr [NS+1];
  logic [QB-1:0] qc [NS+1];
  logic [QB-1:0] qr [NS+1];
  logic          oc [NS+1];
  logic          orr [NS+1];

  logic                       out_tvalid_r;
  logic [hwi_pkg::OUT_W-1:0]  out_tdata_r;
  logic                       okc, okr, ok;
  logic [CB-1:0]              ci, rj;
  hwi_pkg::hwi_side_t         sl;

  assign en        = !out_tvalid_r || out_tready;
  assign in_tready = en;
  assign ci = in_tdata[CB-1:0];
  assign rj = in_tdata[hwi_pkg::FIELD_W +: CB];

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < hwi_pkg::NUM_COEF; k++) coef_r[k] <= '0;
      coef_r[hwi_pkg::IDX_A] <= ONE_C;
      coef_r[hwi_pkg::IDX_E] <= ONE_C;
    end else if (cfg_we) begin
      coef_r[cfg_idx] <= cfg_wdata;
    end
  end

  hwi_mac #(.CB(CB), .SW(SW), .NW(NW)) u_mac (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_i  (in_tvalid),
    .col_i  (ci),
    .row_i  (rj),
    .coef_i (coef_r),
    .vld_o  (fe_vld),
    .nc_o   (fe_nc),
    .nr_o   (fe_nr),
    .d_o    (fe_d),
    .side_o (fe_side)
  );

  assign dc[0]  = fe_d;
  assign dr[0]  = fe_d;
  assign rc[0]  = fe_nc;
  assign rr[0]  = fe_nr;
  assign qc[0]  = '0;
  assign qr[0]  = '0;
  assign oc[0]  = 1'b0;
  assign orr[0] = 1'b0;

  // division chains, most significant step first
  generate
    for (genvar s = 0; s < NS; s++) begin : g_div
      hwi_div_step #(.DW(NW), .RW(NW), .QB(QB), .K(QB - s)) u_col (
        .clk (clk), .en (en),
        .d_i (dc[s]), .rem_i (rc[s]), .q_i (qc[s]), .ovf_i (oc[s]),
        .d_o (dc[s+1]), .rem_o (rc[s+1]), .q_o (qc[s+1]), .ovf_o (oc[s+1])
      );
      hwi_div_step #(.DW(NW), .RW(NW), .QB(QB), .K(QB - s)) u_row (
        .clk (clk), .en (en),
        .d_i (dr[s]), .rem_i (rr[s]), .q_i (qr[s]), .ovf_i (orr[s]),
        .d_o (dr[s+1]), .rem_o (rr[s+1]), .q_o (qr[s+1]), .ovf_o (orr[s+1])
      );
    end
  endgenerate

  // valid bits and flags beside the divider
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NS; k++) vld_r[k] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= fe_vld;
      for (int k = 1; k < NS; k++) vld_r[k] <= vld_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= fe_side;
      for (int k = 1; k < NS; k++) side_r[k] <= side_r[k-1];
    end
  end

  // bounds check
  assign sl  = side_r[NS-1];
  assign okc = !sl.negc && !oc[NS] && (qc[NS] != '0) && (qc[NS] < LIM_C);
  assign okr = !sl.negr && !orr[NS] && (qr[NS] != '0) && (qr[NS] < LIM_R);
  assign ok  = !sl.wz && okc && okr;

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (en) begin
      out_tvalid_r <= vld_r[NS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_tdata_r <= hwi_pkg::OUT_W'({
        ok ? qc[NS][hwi_pkg::FIELD_W-1:0] : 12'd0,
        ok ? qr[NS][hwi_pkg::FIELD_W-1:0] : 12'd0,
        ok});
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

// File: design/hwi_mac.sv
// Front end: products, sums and divider operand setup (three stages).
module hwi_mac #(
  parameter int CB = 12,
  parameter int SW = hwi_pkg::COEF_W + CB + 3,
  parameter int NW = SW + 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                vld_i,
  input  logic [CB-1:0]       col_i,
  input  logic [CB-1:0]       row_i,
  input  hwi_pkg::coef_t      coef_i [hwi_pkg::NUM_COEF],
  output logic                vld_o,
  output logic [NW-1:0]       nc_o,
  output logic [NW-1:0]       nr_o,
  output logic [NW-1:0]       d_o,
  output hwi_pkg::hwi_side_t  side_o
);

  localparam int PW = hwi_pkg::COEF_W + CB + 1;
  localparam logic signed [SW-1:0] ONE_Q =
    {{(SW-hwi_pkg::FRAC_W-1){1'b0}}, 1'b1, {hwi_pkg::FRAC_W{1'b0}}};

  typedef hwi_pkg::hwi_side_t hwi_side_t_w;

  logic [2:0] vld_r;

  logic signed [PW-1:0] pa_r, pb_r, pd_r, pe_r, pg_r, ph_r;
  logic signed [SW-1:0] c_r, f_r;
  logic signed [SW-1:0] x_r, y_r, w_r;
  logic [NW-1:0]        nc_r, nr_r, d_r;
  hwi_side_t_w          side_r;

  logic signed [PW-1:0] ci_s, rj_s;
  logic [SW-1:0]        mx, my, mw;

  assign ci_s = PW'(signed'({1'b0, col_i}));
  assign rj_s = PW'(signed'({1'b0, row_i}));

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[1:0], vld_i};
    end
  end

  // stage 1: coefficient times coordinate
  always_ff @(posedge clk) begin
    if (en) begin
      pa_r <= PW'(coef_i[hwi_pkg::IDX_A]) * ci_s;
      pb_r <= PW'(coef_i[hwi_pkg::IDX_B]) * rj_s;
      pd_r <= PW'(coef_i[hwi_pkg::IDX_D]) * ci_s;
      pe_r <= PW'(coef_i[hwi_pkg::IDX_E]) * rj_s;
      pg_r <= PW'(coef_i[hwi_pkg::IDX_G]) * ci_s;
      ph_r <= PW'(coef_i[hwi_pkg::IDX_H]) * rj_s;
      c_r  <= SW'(coef_i[hwi_pkg::IDX_C]);
      f_r  <= SW'(coef_i[hwi_pkg::IDX_F]);
    end
  end

  // stage 2: homogeneous coordinates
  always_ff @(posedge clk) begin
    if (en) begin
      x_r <= SW'(pa_r) + SW'(pb_r) + c_r;
      y_r <= SW'(pd_r) + SW'(pe_r) + f_r;
      w_r <= SW'(pg_r) + SW'(ph_r) + ONE_Q;
    end
  end

  // stage 3: magnitudes, rounding offset folded into the numerators
  assign mx = x_r[SW-1] ? SW'(-x_r) : SW'(x_r);
  assign my = y_r[SW-1] ? SW'(-y_r) : SW'(y_r);
  assign mw = w_r[SW-1] ? SW'(-w_r) : SW'(w_r);

  always_ff @(posedge clk) begin
    if (en) begin
      nc_r   <= {mx, 1'b0} + NW'(mw);
      nr_r   <= {my, 1'b0} + NW'(mw);
      d_r    <= {mw, 1'b0};
      side_r <= '{wz:   (w_r == '0),
                  negc: x_r[SW-1] ^ w_r[SW-1],
                  negr: y_r[SW-1] ^ w_r[SW-1]};
    end
  end

  assign vld_o  = vld_r[2];
  assign nc_o   = nc_r;
  assign nr_o   = nr_r;
  assign d_o    = d_r;
  assign side_o = side_r;

endmodule

// File: design/hwi_div_step.sv
// One registered restoring-division step; the top step only flags overflow.
module hwi_div_step #(
  parameter int DW = 64,
  parameter int RW = 64,
  parameter int QB = 13,
  parameter int K  = 0
) (
  input  logic          clk,
  input  logic          en,
  input  logic [DW-1:0] d_i,
  input  logic [RW-1:0] rem_i,
  input  logic [QB-1:0] q_i,
  input  logic          ovf_i,
  output logic [DW-1:0] d_o,
  output logic [RW-1:0] rem_o,
  output logic [QB-1:0] q_o,
  output logic          ovf_o
);

  localparam int TW = DW + QB + 1;

  logic [TW-1:0] dsh, rx;
  logic          ge;
  logic [DW-1:0] d_r;
  logic [RW-1:0] rem_r;
  logic [QB-1:0] q_r;
  logic          ovf_r;

  assign dsh = TW'(d_i) << K;
  assign rx  = TW'(rem_i);
  assign ge  = (rx >= dsh);

  generate
    if (K == QB) begin : g_ovf
      // quotient would not fit: flag it
      always_ff @(posedge clk) begin
        if (en) begin
          d_r   <= d_i;
          rem_r <= rem_i;
          q_r   <= q_i;
          ovf_r <= ovf_i | ge;
        end
      end
    end else begin : g_step
      always_ff @(posedge clk) begin
        if (en) begin
          d_r      <= d_i;
          rem_r    <= ge ? RW'(rx - dsh) : rem_i;
          q_r      <= q_i | (QB'(ge) << K);
          ovf_r    <= ovf_i;
        end
      end
    end
  endgenerate

  assign d_o   = d_r;
  assign rem_o = rem_r;
  assign q_o   = q_r;
  assign ovf_o = ovf_r;

endmodule

// File: design/hwi_chk.sv
// Port-level checker for the homography warp index block, with its bind.
module hwi_chk #(
  parameter int SRC_WIDTH  = 640,
  parameter int SRC_HEIGHT = 480
) (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata
);

  // a held beat stays valid
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("output beat dropped while stalled");

  // intake follows the output register
  a_rdy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("in_tready does not track output stall");

  // outside results carry zeros
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |-> out_tdata[24:1] == 24'd0)
    else $error("invalid result with nonzero coordinates");

  // inside results lie strictly within the source
  a_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[0] |->
      out_tdata[24:13] != 12'd0 && 32'(out_tdata[24:13]) < SRC_WIDTH &&
      out_tdata[12:1] != 12'd0 && 32'(out_tdata[12:1]) < SRC_HEIGHT)
    else $error("inside result out of source bounds");

  // padding stays clear
  a_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[31:25] == 7'd0)
    else $error("padding bits set");

endmodule

bind homography_warp_index_top hwi_chk #(
  .SRC_WIDTH  (SRC_WIDTH),
  .SRC_HEIGHT (SRC_HEIGHT)
) u_hwi_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
